// ===== rtl/core/wrs_pkg.sv =====
// Shared types, constants and helpers for the weighted roulette selector.
package wrs_pkg;

  localparam int unsigned ENTRIES     = 64;
  localparam int unsigned WEIGHT_BITS = 16;
  localparam int unsigned INDEX_BITS  = 6;
  localparam int unsigned SIZE_BITS   = 7;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned TOTAL_BITS  = WEIGHT_BITS + $clog2(ENTRIES);
  localparam int unsigned NEWW_BITS   = WEIGHT_BITS + 1;
  localparam int unsigned PROD_BITS   = FRAC_BITS + TOTAL_BITS;

  localparam logic [SIZE_BITS-1:0]   ENTRIES_SZ = SIZE_BITS'(ENTRIES);
  localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = '1;

  typedef enum logic [1:0] {
    KIND_SET    = 2'd0,
    KIND_READ   = 2'd1,
    KIND_SELECT = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    CFG_MIN_WEIGHT = 2'd0,
    CFG_MAX_WEIGHT = 2'd1,
    CFG_WHEEL_SIZE = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LAUNCH,
    ST_RUN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic                   valid;
    logic                   done;
    kind_e                  op;
    logic [SIZE_BITS-1:0]   remain;
    logic [TOTAL_BITS-1:0]  choice;
    logic [WEIGHT_BITS-1:0] weight;
    logic [SIZE_BITS-1:0]   count;
  } tok_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] weight;
    logic [SIZE_BITS-1:0]   sel;
    logic                   err;
  } res_t;

  function automatic logic [WEIGHT_BITS-1:0] clamp_weight(
    input logic [NEWW_BITS-1:0]   raw,
    input logic [WEIGHT_BITS-1:0] lo,
    input logic [WEIGHT_BITS-1:0] hi
  );
    logic [NEWW_BITS-1:0]   mag;
    logic [WEIGHT_BITS-1:0] res;
    mag = raw[NEWW_BITS-1] ? (NEWW_BITS'(0) - raw) : raw;
    if (mag < {1'b0, lo}) begin
      res = lo;
    end else if (mag > {1'b0, hi}) begin
      res = hi;
    end else begin
      res = mag[WEIGHT_BITS-1:0];
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/wrs_if.sv =====
// Valid/ready channel interfaces for request and result items.
interface wrs_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             kind;
  logic [wrs_pkg::INDEX_BITS-1:0]         entry_index;
  logic signed [wrs_pkg::NEWW_BITS-1:0]   new_weight;
  logic [wrs_pkg::FRAC_BITS-1:0]          random_fraction;

  modport source (output valid, kind, entry_index, new_weight, random_fraction,
                  input ready);
  modport sink   (input valid, kind, entry_index, new_weight, random_fraction,
                  output ready);
endinterface

interface wrs_out_if;
  logic                             valid;
  logic                             ready;
  logic [wrs_pkg::WEIGHT_BITS-1:0]  weight_out;
  logic [wrs_pkg::SIZE_BITS-1:0]    selected_index;
  logic                             index_error;

  modport source (output valid, weight_out, selected_index, index_error,
                  input ready);
  modport sink   (input valid, weight_out, selected_index, index_error,
                  output ready);
endinterface

// ===== rtl/core/wrs_cell.sv =====
// One table entry: holds a weight and processes the token passing through.
module wrs_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  wrs_pkg::tok_t tok_i,
  output wrs_pkg::tok_t tok_o
);
  import wrs_pkg::*;

  logic [WEIGHT_BITS-1:0] w_q, w_d;
  tok_t                   tok_q, tok_d;

  always_comb begin
    tok_d = tok_i;
    w_d   = w_q;
    if (tok_i.valid && !tok_i.done) begin
      case (tok_i.op)
        KIND_SELECT: begin
          if (tok_i.remain == '0 || tok_i.choice <= TOTAL_BITS'(w_q)) begin
            tok_d.done = 1'b1;
          end else begin
            tok_d.choice = tok_i.choice - TOTAL_BITS'(w_q);
            tok_d.count  = tok_i.count + SIZE_BITS'(1);
            tok_d.remain = tok_i.remain - SIZE_BITS'(1);
          end
        end
        KIND_SET, KIND_READ: begin
          if (tok_i.remain == '0) begin
            tok_d.weight = w_q;
            tok_d.done   = 1'b1;
            if (tok_i.op == KIND_SET) begin
              w_d = tok_i.weight;
            end
          end else begin
            tok_d.remain = tok_i.remain - SIZE_BITS'(1);
          end
        end
        default: begin
          tok_d.done = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q   <= '0;
      tok_q <= '0;
    end else begin
      w_q   <= w_d;
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// ===== rtl/core/weighted_roulette_selector.sv =====
// Weighted roulette selector: a row of weight cells walked by one token per item.
//
// Request items arrive on in_i (valid/ready); each gives one result item on out_o.
// kind set stores a clamped weight and returns the old one, read returns a weight,
// select returns the index picked by a 16-bit random fraction scaled by the total.
// Configuration registers (min_weight, max_weight, wheel_size) are written through
// cfg_we_i/cfg_idx_i/cfg_data_i. The user must write them only while the block is idle;
// the block itself does not enforce this. Set, read and select go from acceptance to
// the result register in steps: the fraction x total multiply, the token launch,
// then the token crosses the row one cell after another.
// An out-of-range index or an unknown kind answers without a walk.
// One item is worked at a time; a new item is taken once the previous result has
// left the row, even while that result still waits at out_o.
// Reset clears every weight and the total at once and loads the register defaults.
// When the receiver stalls, the result holds at out_o and a finished next result
// waits in the block until the output register frees up.
module weighted_roulette_selector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  wrs_in_if.sink                              in_i,
  wrs_out_if.source                           out_o,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [wrs_pkg::WEIGHT_BITS-1:0]     cfg_data_i
);
  import wrs_pkg::*;

  state_e                 state_q, state_d;
  logic [WEIGHT_BITS-1:0] min_q, max_q;
  logic [SIZE_BITS-1:0]   size_q, used;
  logic [TOTAL_BITS-1:0]  total_q, total_d;
  kind_e                  op_q;
  logic [INDEX_BITS-1:0]  idx_q;
  logic [FRAC_BITS-1:0]   frac_q;
  logic [WEIGHT_BITS-1:0] wnew_q;
  logic [PROD_BITS-1:0]   prod_q;
  res_t                   res_q, res_d;
  logic                   out_valid_q;
  res_t                   out_q;
  logic                   in_fire, out_free;
  kind_e                  in_kind;
  tok_t                   head, tail;
  tok_t                   chain [ENTRIES+1];
  logic [ENTRIES-1:0]     tok_valid;

  assign used     = (size_q > ENTRIES_SZ) ? ENTRIES_SZ : size_q;
  assign in_kind  = kind_e'(in_i.kind);
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= '0;
      max_q  <= WEIGHT_MAX;
      size_q <= ENTRIES_SZ;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_WEIGHT: min_q  <= cfg_data_i;
        CFG_MAX_WEIGHT: max_q  <= cfg_data_i;
        CFG_WHEEL_SIZE: size_q <= cfg_data_i[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= in_kind;
      idx_q  <= in_i.entry_index;
      frac_q <= in_i.random_fraction;
      wnew_q <= clamp_weight(in_i.new_weight, min_q, max_q);
    end
    if (state_q == ST_MUL) begin
      prod_q <= PROD_BITS'(frac_q) * PROD_BITS'(total_q);
    end
    res_q <= res_d;
  end

  always_comb begin
    head        = '0;
    head.valid  = (state_q == ST_LAUNCH);
    head.op     = op_q;
    head.choice = prod_q[PROD_BITS-1:FRAC_BITS];
    head.weight = wnew_q;
    head.remain = (op_q == KIND_SELECT) ? used : SIZE_BITS'(idx_q);
  end

  assign chain[0] = head;
  assign tail     = chain[ENTRIES];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    wrs_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (chain[g]),
      .tok_o  (chain[g+1])
    );
    assign tok_valid[g] = chain[g+1].valid;
  end

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    total_d = total_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          res_d = '0;
          if ((in_kind == KIND_SET || in_kind == KIND_READ)
              && SIZE_BITS'(in_i.entry_index) >= used) begin
            res_d.err = 1'b1;
            state_d   = ST_FINISH;
          end else if (in_kind == KIND_NONE) begin
            state_d = ST_FINISH;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL:    state_d = ST_LAUNCH;
      ST_LAUNCH: state_d = ST_RUN;
      ST_RUN: begin
        if (tail.valid) begin
          res_d = '0;
          if (op_q == KIND_SELECT) begin
            res_d.sel = tail.count;
          end else begin
            res_d.weight = tail.weight;
          end
          if (op_q == KIND_SET) begin
            total_d = total_q - TOTAL_BITS'(tail.weight) + TOTAL_BITS'(wnew_q);
          end
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      if (state_q == ST_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FINISH && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.weight_out     = out_q.weight;
  assign out_o.selected_index = out_q.sel;
  assign out_o.index_error    = out_q.err;

  a_tail_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> state_q == ST_RUN)
    else $error("token left the row outside the run state");

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_valid) <= 1)
    else $error("more than one token in the row");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && res_q.err) |-> (res_q.weight == '0 && res_q.sel == '0))
    else $error("error result carries data");

  a_total_only_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q != $past(total_q)) |-> ($past(state_q) == ST_RUN && $past(op_q) == KIND_SET))
    else $error("total changed outside a set");

endmodule
